[rtl/spb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_pkg: shared types and constants for the stereo peaking biquad
// Widths, register map, sequencer step codes and the command bundle that the
// controller sends to the datapath.
// ----------------------------------------------------------------------------
package spb_pkg;

  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 28;
  localparam int COEF_BITS          = 32;
  localparam int DELAY_BITS         = 40;
  localparam int NUM_COEFS          = 8;
  localparam int COEF_ADDR_BITS     = 3;
  localparam int CFG_INDEX_BITS     = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // per-channel schedule; products pass prod and term before accumulation
  typedef enum logic [3:0] {
    STEP_MUL_B0,
    STEP_MUL_B1X,
    STEP_MUL_B2X,
    STEP_TAKE_Y,
    STEP_MUL_B1Y,
    STEP_MUL_A2Y,
    STEP_SUB_B1Y,
    STEP_SUB_A2Y,
    STEP_STORE
  } step_t;

  // coefficient slot inside one channel's group of four registers
  typedef enum logic [1:0] {
    COEF_B0,
    COEF_B1,
    COEF_B2,
    COEF_A2
  } coef_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_D1,
    ACC_ADD_TERM,
    ACC_LOAD_TERM,
    ACC_SUB_TERM
  } acc_op_t;

  typedef enum logic [1:0] {
    ACC2_HOLD,
    ACC2_LOAD_D2,
    ACC2_SUB_TERM
  } acc2_op_t;

  typedef struct packed {
    logic      load_in;
    logic      chan;
    coef_sel_t coef_sel;
    logic      mul_op_y;
    acc_op_t   acc_op;
    acc2_op_t  acc2_op;
    logic      take_y;
    logic      store;
    logic      out_load;
  } cmd_t;

endpackage

[rtl/spb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_ctrl: frame sequencer
// Walks both channels through the nine-step multiply/accumulate schedule and
// owns the input and output handshakes.
// ----------------------------------------------------------------------------
module spb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output spb_pkg::cmd_t cmd
);

  spb_pkg::state_t state, state_next;
  spb_pkg::step_t  step, step_next;
  logic            chan, chan_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spb_pkg::ST_IDLE;
      step      <= spb_pkg::STEP_MUL_B0;
      chan      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      chan      <= chan_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == spb_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    step_next      = step;
    chan_next      = chan;
    out_valid_next = out_valid;
    cmd            = '0;
    cmd.chan       = chan;
    cmd.coef_sel   = spb_pkg::COEF_B0;
    cmd.acc_op     = spb_pkg::ACC_HOLD;
    cmd.acc2_op    = spb_pkg::ACC2_HOLD;

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      spb_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = spb_pkg::ST_RUN;
          step_next   = spb_pkg::STEP_MUL_B0;
          chan_next   = 1'b0;
        end
      end
      spb_pkg::ST_RUN: begin
        step_next = spb_pkg::step_t'(step + 4'd1);
        case (step)
          spb_pkg::STEP_MUL_B0: begin
            cmd.coef_sel = spb_pkg::COEF_B0;
            cmd.acc_op   = spb_pkg::ACC_LOAD_D1;
          end
          spb_pkg::STEP_MUL_B1X: begin
            cmd.coef_sel = spb_pkg::COEF_B1;
          end
          spb_pkg::STEP_MUL_B2X: begin
            cmd.coef_sel = spb_pkg::COEF_B2;
            cmd.acc_op   = spb_pkg::ACC_ADD_TERM;  // b0*x + d1
          end
          spb_pkg::STEP_TAKE_Y: begin
            cmd.acc2_op = spb_pkg::ACC2_LOAD_D2;   // b1*x + d2
            cmd.take_y  = 1'b1;
          end
          spb_pkg::STEP_MUL_B1Y: begin
            cmd.coef_sel = spb_pkg::COEF_B1;
            cmd.mul_op_y = 1'b1;
            cmd.acc_op   = spb_pkg::ACC_LOAD_TERM; // b2*x
          end
          spb_pkg::STEP_MUL_A2Y: begin
            cmd.coef_sel = spb_pkg::COEF_A2;
            cmd.mul_op_y = 1'b1;
          end
          spb_pkg::STEP_SUB_B1Y: begin
            cmd.acc2_op = spb_pkg::ACC2_SUB_TERM;
          end
          spb_pkg::STEP_SUB_A2Y: begin
            cmd.acc_op = spb_pkg::ACC_SUB_TERM;
          end
          spb_pkg::STEP_STORE: begin
            cmd.store = 1'b1;
            step_next = spb_pkg::STEP_MUL_B0;
            if (chan) begin
              state_next = spb_pkg::ST_FINISH;
            end else begin
              chan_next = 1'b1;
            end
          end
          default: begin
            step_next = spb_pkg::STEP_MUL_B0;
          end
        endcase
      end
      spb_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = spb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/spb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_datapath: coefficient bank, shared multiplier and accumulators
// One signed multiply per cycle, a rounding stage, two accumulators, the
// output round/saturate and the four saturating delay registers.
// ----------------------------------------------------------------------------
module spb_datapath #(
  parameter int SAMPLE_BITS    = spb_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = spb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  spb_pkg::cmd_t                       cmd,
  input  logic                                cfg_valid,
  input  logic [spb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [spb_pkg::COEF_BITS-1:0]       cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]       sample_left,
  input  logic signed [SAMPLE_BITS-1:0]       sample_right,
  input  logic                                restart,
  output logic signed [SAMPLE_BITS-1:0]       out_left,
  output logic signed [SAMPLE_BITS-1:0]       out_right,
  output logic                                clipped
);

  localparam int CW    = spb_pkg::COEF_BITS;
  localparam int DW    = spb_pkg::DELAY_BITS;
  localparam int GUARD = DW - SAMPLE_BITS - 8;
  localparam int SHIFT = COEF_FRAC_BITS - GUARD;
  localparam int PW    = CW + SAMPLE_BITS;
  localparam int AW    = PW + 2;

  localparam logic signed [CW-1:0] COEF_ONE   = CW'(1) << COEF_FRAC_BITS;
  localparam logic signed [PW:0]   HALF_SHIFT = ((PW + 1)'(1) << SHIFT) >> 1;
  localparam logic signed [AW:0]   HALF_GUARD = ((AW + 1)'(1) << GUARD) >> 1;
  localparam logic signed [AW:0]   Y_MAX = {{(AW + 2 - SAMPLE_BITS){1'b0}},
                                            {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [AW:0]   Y_MIN = {{(AW + 2 - SAMPLE_BITS){1'b1}},
                                            {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic signed [AW-1:0] D_MAX = {{(AW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [AW-1:0] D_MIN = {{(AW - DW + 1){1'b1}}, {(DW - 1){1'b0}}};

  logic signed [CW-1:0]          coef [spb_pkg::NUM_COEFS];
  logic signed [SAMPLE_BITS-1:0] x [2];
  logic signed [SAMPLE_BITS-1:0] y [2];
  logic signed [DW-1:0]          d1 [2];
  logic signed [DW-1:0]          d2 [2];
  logic signed [PW-1:0]          prod;
  logic signed [AW-1:0]          term;
  logic signed [AW-1:0]          acc;
  logic signed [AW-1:0]          acc2;
  logic                          clip_work;

  logic [spb_pkg::COEF_ADDR_BITS-1:0] coef_addr;
  logic signed [CW-1:0]               coef_rd;
  logic signed [SAMPLE_BITS-1:0]      mul_op;
  logic signed [PW:0]                 prod_rnd;
  logic signed [PW:0]                 term_next;
  logic signed [AW-1:0]               d1_ext;
  logic signed [AW-1:0]               d2_ext;
  logic signed [AW:0]                 y_sum;
  logic signed [AW:0]                 y_rnd;
  logic signed [SAMPLE_BITS-1:0]      y_sat;
  logic                               y_hit;
  logic signed [DW-1:0]               n1_sat;
  logic signed [DW-1:0]               n2_sat;

  assign coef_addr = {cmd.chan, cmd.coef_sel};
  assign coef_rd   = coef[coef_addr];
  assign mul_op    = cmd.mul_op_y ? y[cmd.chan] : x[cmd.chan];

  // round half up: add half an LSB, then arithmetic shift
  assign prod_rnd  = $signed({prod[PW-1], prod}) + HALF_SHIFT;
  assign term_next = prod_rnd >>> SHIFT;

  assign d1_ext = {{(AW - DW){d1[cmd.chan][DW-1]}}, d1[cmd.chan]};
  assign d2_ext = {{(AW - DW){d2[cmd.chan][DW-1]}}, d2[cmd.chan]};

  assign y_sum = $signed({acc[AW-1], acc}) + HALF_GUARD;
  assign y_rnd = y_sum >>> GUARD;

  always_comb begin
    y_hit = 1'b0;
    if (y_rnd > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
      y_hit = 1'b1;
    end else if (y_rnd < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
      y_hit = 1'b1;
    end else begin
      y_sat = y_rnd[SAMPLE_BITS-1:0];
    end
  end

  // delay terms clamp silently
  always_comb begin
    if (acc2 > D_MAX) begin
      n1_sat = D_MAX[DW-1:0];
    end else if (acc2 < D_MIN) begin
      n1_sat = D_MIN[DW-1:0];
    end else begin
      n1_sat = acc2[DW-1:0];
    end
    if (acc > D_MAX) begin
      n2_sat = D_MAX[DW-1:0];
    end else if (acc < D_MIN) begin
      n2_sat = D_MIN[DW-1:0];
    end else begin
      n2_sat = acc[DW-1:0];
    end
  end

  // coefficients and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < spb_pkg::NUM_COEFS; i++) begin
        coef[i] <= ((i % 4) == 0) ? COEF_ONE : '0;
      end
      for (int c = 0; c < 2; c++) begin
        d1[c] <= '0;
        d2[c] <= '0;
      end
    end else begin
      if (cfg_valid && (cfg_index < spb_pkg::CFG_INDEX_BITS'(spb_pkg::NUM_COEFS))) begin
        coef[cfg_index[spb_pkg::COEF_ADDR_BITS-1:0]] <= cfg_data;
      end
      if (cmd.load_in && restart) begin
        for (int c = 0; c < 2; c++) begin
          d1[c] <= '0;
          d2[c] <= '0;
        end
      end else if (cmd.store) begin
        d1[cmd.chan] <= n1_sat;
        d2[cmd.chan] <= n2_sat;
      end
    end
  end

  // arithmetic pipeline and result registers
  always_ff @(posedge clk) begin
    prod <= coef_rd * mul_op;
    term <= {{(AW - PW - 1){term_next[PW]}}, term_next};

    case (cmd.acc_op)
      spb_pkg::ACC_LOAD_D1:   acc <= d1_ext;
      spb_pkg::ACC_ADD_TERM:  acc <= acc + term;
      spb_pkg::ACC_LOAD_TERM: acc <= term;
      spb_pkg::ACC_SUB_TERM:  acc <= acc - term;
      default:                acc <= acc;
    endcase

    case (cmd.acc2_op)
      spb_pkg::ACC2_LOAD_D2:  acc2 <= d2_ext + term;
      spb_pkg::ACC2_SUB_TERM: acc2 <= acc2 - term;
      default:                acc2 <= acc2;
    endcase

    if (cmd.load_in) begin
      x[0]      <= sample_left;
      x[1]      <= sample_right;
      clip_work <= 1'b0;
    end else if (cmd.take_y) begin
      y[cmd.chan] <= y_sat;
      clip_work   <= clip_work | y_hit;
    end

    if (cmd.out_load) begin
      out_left  <= y[0];
      out_right <= y[1];
      clipped   <= clip_work;
    end
  end

endmodule

[rtl/stereo_peaking_biquad_df2t_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_peaking_biquad_df2t_core: stereo peaking biquad, transposed DF-II
// Fixed-point second-order section per channel with saturating output and
// clip flag; one shared multiplier sequenced by a small controller.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one beat is a stereo frame, Q1.23
//   samples plus a restart bit that zeroes all delay state first.
//   Output channel (out_valid/out_ready): one beat per frame with both
//   filtered, saturated samples and a clip flag.
//   Config channel (cfg_valid/cfg_ready): cfg_index 0..7 selects
//   left b0,b1,b2,a2 then right b0,b1,b2,a2 (Q4.28); b1 doubles as a1.
//   Indexes 8 and up are dropped. cfg_ready is always high; write only
//   while no frame is in flight.
// Timing
//   Each channel runs its schedule on the shared multiplier (five products,
//   each through the multiply register and then the rounding register).
//   A frame is accepted in idle; the sequencer runs left, then right, then
//   loads the output register, raising out_valid, before it takes a new frame.
//   The output register is separate from the working registers: a new frame
//   is accepted while the previous result still waits. If that result is
//   still not taken when the next frame finishes, the sequencer holds in its
//   finish state until out_ready.
// Reset
//   rst (synchronous) restores the default coefficients (unity b0, others
//   zero), zeroes delay state and drops out_valid.
// ----------------------------------------------------------------------------
module stereo_peaking_biquad_df2t_core #(
  parameter int SAMPLE_BITS    = spb_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = spb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // frame input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      sample_left,
  input  logic signed [SAMPLE_BITS-1:0]      sample_right,
  input  logic                               restart,
  // frame output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      out_left,
  output logic signed [SAMPLE_BITS-1:0]      out_right,
  output logic                               clipped,
  // coefficient writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [spb_pkg::COEF_BITS-1:0]      cfg_data
);

  spb_pkg::cmd_t cmd;

  // coefficient bank is a plain register file: writes never stall
  assign cfg_ready = 1'b1;

  spb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  spb_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .restart      (restart),
    .out_left     (out_left),
    .out_right    (out_right),
    .clipped      (clipped)
  );

endmodule

[rtl/spb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spb_checker: port-level checks for the stereo peaking biquad
// Watches handshakes and result values seen at the top-level ports.
// ----------------------------------------------------------------------------
module spb_checker #(
  parameter int SAMPLE_BITS = spb_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_left,
  input logic signed [SAMPLE_BITS-1:0] out_right,
  input logic                          clipped
);

  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_left) &&
      $stable(out_right) && $stable(clipped))
    else $error("output beat changed while stalled");

  // one frame at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second frame accepted while busy");

  // a new result only appears at the end of a frame's work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without work in flight");

  // clip flag implies a channel sits at a rail
  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (out_left == S_MAX) || (out_left == S_MIN) ||
      (out_right == S_MAX) || (out_right == S_MIN))
    else $error("clip flagged with no saturated output");

endmodule

bind stereo_peaking_biquad_df2t_core spb_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_spb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_left  (out_left),
  .out_right (out_right),
  .clipped   (clipped)
);
